[sv/windowed_min_max_mean_deviation_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the windowed deviation RTL.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MIN_MAX_MEAN_DEVIATION_MACROS_SVH
`define WINDOWED_MIN_MAX_MEAN_DEVIATION_MACROS_SVH

`ifndef SYNTHESIS

`define WMMD_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("wmmd assertion failed");

`define WMMD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wmmd assertion failed");

`define WMMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wmmd assertion failed");

`else

`define WMMD_ASSERT(label, clk, rst, expr)
`define WMMD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WMMD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/wmmd_pkg.sv]
// ----------------------------------------------------------------------------
// Windowed deviation package
// Field widths, register indexes, reset values and state types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wmmd_pkg;

   localparam int TEMP_W     = 11;
   localparam int HUM_W      = 10;
   localparam int TPS_W      = 8;
   localparam int WLEN_W     = 7;
   localparam int TDEV_W     = 12;
   localparam int HDEV_W     = 11;
   localparam int VAL_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_TICKS_PER_STORE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd1;

   localparam logic [TPS_W-1:0]  TPS_RESET  = 8'd60;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd60;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_WALK  = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_START = 6'b001000,
      ST_DIVW  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      SEL_TEMP_MAX = 2'd0,
      SEL_TEMP_MIN = 2'd1,
      SEL_HUM_MAX  = 2'd2,
      SEL_HUM_MIN  = 2'd3
   } sel_type;

endpackage

[sv/wmmd_ifs.sv]
// ----------------------------------------------------------------------------
// Windowed deviation channels
// Valid/ready interfaces for the sample channel and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wmmd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [wmmd_pkg::TEMP_W-1:0] temperature;
   logic        [wmmd_pkg::HUM_W-1:0]  humidity;
   logic                                tick;

   modport source (output valid, output temperature, output humidity, output tick,
                   input ready);
   modport sink   (input valid, input temperature, input humidity, input tick,
                   output ready);
endinterface

interface wmmd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [wmmd_pkg::TDEV_W-1:0] temp_dev_above;
   logic signed [wmmd_pkg::TDEV_W-1:0] temp_dev_below;
   logic signed [wmmd_pkg::HDEV_W-1:0] hum_dev_above;
   logic signed [wmmd_pkg::HDEV_W-1:0] hum_dev_below;
   logic                                updated;

   modport source (output valid, output temp_dev_above, output temp_dev_below,
                   output hum_dev_above, output hum_dev_below, output updated,
                   input ready);
   modport sink   (input valid, input temp_dev_above, input temp_dev_below,
                   input hum_dev_above, input hum_dev_below, input updated,
                   output ready);
endinterface

[sv/wmmd_div.sv]
// ----------------------------------------------------------------------------
// Windowed deviation divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmmd_div #(
   parameter int DW = 21,
   parameter int VW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [VW:0]      shifted;
   logic [VW:0]      diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VW-1:0] : shifted[VW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[sv/windowed_min_max_mean_deviation.sv]
// ----------------------------------------------------------------------------
// Windowed min / max / mean deviation
// Stores tick-paced temperature and humidity samples in a circular window
// memory and reports the maximum and minimum deviation from the window mean.
//
//   Channel   Direction  Handshake      Payload
//   req_ch    in         valid / ready  temperature, humidity, tick
//   rsp_ch    out        valid / ready  four deviations, updated
//   csr_*     in         write enable   register index, write data
//
// A beat that does not store returns the held deviations through the result register.
// A storing beat walks the filled part of the window through the memory read
// port, then runs four roundings through one shared serial divider.
// Reset is synchronous and clears control state; no memory clearing pass.
// A stalled result beat holds req_ch ready low until the output frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_min_max_mean_deviation_macros.svh"

module windowed_min_max_mean_deviation #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   wmmd_req_if.sink                           req_ch,
   wmmd_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [wmmd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wmmd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int VAL_W  = wmmd_pkg::VAL_W;
   localparam int TEMP_W = wmmd_pkg::TEMP_W;
   localparam int HUM_W  = wmmd_pkg::HUM_W;
   localparam int TPS_W  = wmmd_pkg::TPS_W;
   localparam int WLEN_W = wmmd_pkg::WLEN_W;
   localparam int TDEV_W = wmmd_pkg::TDEV_W;
   localparam int HDEV_W = wmmd_pkg::HDEV_W;
   localparam int AW     = $clog2(WINDOW_DEPTH);
   localparam int CW     = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = VAL_W + CW;
   localparam int PROD_W = VAL_W + CW + 1;
   localparam int NUM_W  = PROD_W + 1;
   localparam int MEM_W  = TEMP_W + HUM_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

   // Configuration and window bookkeeping.
   logic [TPS_W-1:0]  tps_ff, tps_in;
   logic [WLEN_W-1:0] wlen_ff, wlen_in;
   logic [AW-1:0]     wr_idx_ff, wr_idx_in;
   logic [CW-1:0]     fill_count_ff, fill_count_in;
   logic [TPS_W-1:0]  tick_cnt_ff, tick_cnt_in;
   wmmd_pkg::state_type state_ff, state_in;

   // Held deviations.
   logic signed [TDEV_W-1:0] tda_ff, tda_in, tdb_ff, tdb_in;
   logic signed [HDEV_W-1:0] hda_ff, hda_in, hdb_ff, hdb_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [TDEV_W-1:0] rsp_tda_ff, rsp_tda_in, rsp_tdb_ff, rsp_tdb_in;
   logic signed [HDEV_W-1:0] rsp_hda_ff, rsp_hda_in, rsp_hdb_ff, rsp_hdb_in;
   logic                     rsp_upd_ff, rsp_upd_in;

   // Window memory and walk.
   logic [MEM_W-1:0]        mem [WINDOW_DEPTH];
   logic [MEM_W-1:0]        rd_data_ff;
   logic [CW-1:0]           iss_ff, iss_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic                    first_ff, first_in;
   logic signed [VAL_W-1:0] mx_ff [2];
   logic signed [VAL_W-1:0] mn_ff [2];
   logic signed [SUM_W-1:0] sum_ff [2];
   logic signed [VAL_W-1:0] mx_in [2];
   logic signed [VAL_W-1:0] mn_in [2];
   logic signed [SUM_W-1:0] sum_in [2];
   logic signed [VAL_W-1:0] lane [2];

   // Division sequencing.
   wmmd_pkg::sel_type        sel_ff, sel_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff, neg_in;

   logic              accept;
   logic              out_free;
   logic              load_idle;
   logic              load_resp;
   logic [TPS_W-1:0]  interval;
   logic              tick_hit;
   logic              store;
   logic [CW-1:0]     len_c;
   logic [AW-1:0]     wi_c;
   logic [CW-1:0]     fill_c;
   logic              rd_en;
   logic signed [VAL_W-1:0] sel_val;
   logic signed [SUM_W-1:0] sel_sum;
   logic signed [NUM_W-1:0] num_c;
   logic [NUM_W-1:0]        mag_c;
   logic [NUM_W-1:0]        dividend_c;
   logic                    div_start;
   logic                    div_done;
   logic [NUM_W-1:0]        quotient;
   logic [NUM_W-1:0]        res_full;
   logic [VAL_W-1:0]        res_c;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == wmmd_pkg::ST_IDLE) && out_free;

   always_comb begin
      if (wlen_ff == '0) begin
         len_c = CW'(1);
      end else if (32'(wlen_ff) > WINDOW_DEPTH) begin
         len_c = DEPTH_C;
      end else begin
         len_c = CW'(wlen_ff);
      end
   end

   assign interval = (tps_ff == '0) ? TPS_W'(1) : tps_ff;
   assign tick_hit = ({1'b0, tick_cnt_ff} + (TPS_W + 1)'(1)) >= {1'b0, interval};
   assign store    = accept && req_ch.tick && tick_hit;
   assign wi_c     = (CW'(wr_idx_ff) >= len_c) ? '0 : wr_idx_ff;
   assign fill_c   = (fill_count_ff > len_c) ? len_c : fill_count_ff;
   assign rd_en    = (state_ff == wmmd_pkg::ST_WALK) && (iss_ff < fill_count_ff);

   assign lane[0] = VAL_W'($signed(rd_data_ff[MEM_W-1:HUM_W]));
   assign lane[1] = $signed(VAL_W'(rd_data_ff[HUM_W-1:0]));

   always_ff @(posedge clock) begin
      if (store) begin
         mem[wi_c] <= {req_ch.temperature, req_ch.humidity};
      end
      if (rd_en) begin
         rd_data_ff <= mem[iss_ff[AW-1:0]];
      end
   end

   always_comb begin
      case (sel_ff)
         wmmd_pkg::SEL_TEMP_MAX: sel_val = mx_ff[0];
         wmmd_pkg::SEL_TEMP_MIN: sel_val = mn_ff[0];
         wmmd_pkg::SEL_HUM_MAX:  sel_val = mx_ff[1];
         default:                sel_val = mn_ff[1];
      endcase
   end

   assign sel_sum    = sel_ff[1] ? sum_ff[1] : sum_ff[0];
   assign num_c      = NUM_W'(prod_ff) - NUM_W'(sel_sum);
   assign mag_c      = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
   assign dividend_c = mag_c + NUM_W'(fill_count_ff >> 1);
   assign div_start  = (state_ff == wmmd_pkg::ST_START);
   assign res_full   = neg_ff ? (~quotient + NUM_W'(1)) : quotient;
   assign res_c      = res_full[VAL_W-1:0];

   wmmd_div #(
      .DW (NUM_W),
      .VW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_c),
      .divisor  (fill_count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign load_idle = accept && !store;
   assign load_resp = (state_ff == wmmd_pkg::ST_RESP) && out_free;

   always_comb begin
      tps_in        = tps_ff;
      wlen_in       = wlen_ff;
      wr_idx_in     = wr_idx_ff;
      fill_count_in = fill_count_ff;
      tick_cnt_in   = tick_cnt_ff;
      state_in      = state_ff;
      tda_in        = tda_ff;
      tdb_in        = tdb_ff;
      hda_in        = hda_ff;
      hdb_in        = hdb_ff;
      iss_in        = iss_ff;
      rd_vld_in     = rd_en;
      first_in      = first_ff;
      sel_in        = sel_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      for (int c = 0; c < 2; c++) begin
         mx_in[c]  = mx_ff[c];
         mn_in[c]  = mn_ff[c];
         sum_in[c] = sum_ff[c];
      end

      if (accept && req_ch.tick) begin
         tick_cnt_in = tick_hit ? '0 : tick_cnt_ff + TPS_W'(1);
      end

      if (store) begin
         wr_idx_in     = ((CW'(wi_c) + CW'(1)) >= len_c) ? '0 : wi_c + AW'(1);
         fill_count_in = (fill_c < len_c) ? fill_c + CW'(1) : fill_c;
         iss_in        = '0;
         first_in      = 1'b1;
      end

      if (rd_en) begin
         iss_in = iss_ff + CW'(1);
      end

      if (rd_vld_ff) begin
         first_in = 1'b0;
         for (int c = 0; c < 2; c++) begin
            if (first_ff) begin
               mx_in[c]  = lane[c];
               mn_in[c]  = lane[c];
               sum_in[c] = SUM_W'(lane[c]);
            end else begin
               if (lane[c] > mx_ff[c]) mx_in[c] = lane[c];
               if (lane[c] < mn_ff[c]) mn_in[c] = lane[c];
               sum_in[c] = sum_ff[c] + SUM_W'(lane[c]);
            end
         end
      end

      case (state_ff)
         wmmd_pkg::ST_IDLE: begin
            if (store) state_in = wmmd_pkg::ST_WALK;
         end
         wmmd_pkg::ST_WALK: begin
            if (!rd_en && !rd_vld_ff) begin
               state_in = wmmd_pkg::ST_MUL;
               sel_in   = wmmd_pkg::SEL_TEMP_MAX;
            end
         end
         wmmd_pkg::ST_MUL: begin
            prod_in  = PROD_W'(sel_val) * PROD_W'($signed({1'b0, fill_count_ff}));
            state_in = wmmd_pkg::ST_START;
         end
         wmmd_pkg::ST_START: begin
            neg_in   = num_c[NUM_W-1];
            state_in = wmmd_pkg::ST_DIVW;
         end
         wmmd_pkg::ST_DIVW: begin
            if (div_done) begin
               case (sel_ff)
                  wmmd_pkg::SEL_TEMP_MAX: tda_in = $signed(res_c[TDEV_W-1:0]);
                  wmmd_pkg::SEL_TEMP_MIN: tdb_in = $signed(res_c[TDEV_W-1:0]);
                  wmmd_pkg::SEL_HUM_MAX:  hda_in = $signed(res_c[HDEV_W-1:0]);
                  default:                hdb_in = $signed(res_c[HDEV_W-1:0]);
               endcase
               if (sel_ff == wmmd_pkg::SEL_HUM_MIN) begin
                  state_in = wmmd_pkg::ST_RESP;
               end else begin
                  sel_in   = wmmd_pkg::sel_type'(sel_ff + 2'd1);
                  state_in = wmmd_pkg::ST_MUL;
               end
            end
         end
         wmmd_pkg::ST_RESP: begin
            if (out_free) state_in = wmmd_pkg::ST_IDLE;
         end
         default: state_in = wmmd_pkg::ST_IDLE;
      endcase

      if (csr_we) begin
         case (csr_index)
            wmmd_pkg::REG_TICKS_PER_STORE: begin
               tps_in = csr_wdata[TPS_W-1:0];
            end
            wmmd_pkg::REG_WINDOW_LENGTH: begin
               wlen_in       = csr_wdata[WLEN_W-1:0];
               wr_idx_in     = '0;
               fill_count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_tda_in   = rsp_tda_ff;
      rsp_tdb_in   = rsp_tdb_ff;
      rsp_hda_in   = rsp_hda_ff;
      rsp_hdb_in   = rsp_hdb_ff;
      rsp_upd_in   = rsp_upd_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;
      if (load_idle || load_resp) begin
         rsp_valid_in = 1'b1;
         rsp_tda_in   = tda_ff;
         rsp_tdb_in   = tdb_ff;
         rsp_hda_in   = hda_ff;
         rsp_hdb_in   = hdb_ff;
         rsp_upd_in   = load_resp;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tda_ff <= rsp_tda_in;
      rsp_tdb_ff <= rsp_tdb_in;
      rsp_hda_ff <= rsp_hda_in;
      rsp_hdb_ff <= rsp_hdb_in;
      rsp_upd_ff <= rsp_upd_in;
      iss_ff     <= iss_in;
      first_ff   <= first_in;
      sel_ff     <= sel_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      for (int c = 0; c < 2; c++) begin
         mx_ff[c]  <= mx_in[c];
         mn_ff[c]  <= mn_in[c];
         sum_ff[c] <= sum_in[c];
      end
      if (reset) begin
         tps_ff        <= wmmd_pkg::TPS_RESET;
         wlen_ff       <= wmmd_pkg::WLEN_RESET;
         wr_idx_ff     <= '0;
         fill_count_ff <= '0;
         tick_cnt_ff   <= '0;
         state_ff      <= wmmd_pkg::ST_IDLE;
         tda_ff        <= '0;
         tdb_ff        <= '0;
         hda_ff        <= '0;
         hdb_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         tps_ff        <= tps_in;
         wlen_ff       <= wlen_in;
         wr_idx_ff     <= wr_idx_in;
         fill_count_ff <= fill_count_in;
         tick_cnt_ff   <= tick_cnt_in;
         state_ff      <= state_in;
         tda_ff        <= tda_in;
         tdb_ff        <= tdb_in;
         hda_ff        <= hda_in;
         hdb_ff        <= hdb_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.temp_dev_above = rsp_tda_ff;
   assign rsp_ch.temp_dev_below = rsp_tdb_ff;
   assign rsp_ch.hum_dev_above  = rsp_hda_ff;
   assign rsp_ch.hum_dev_below  = rsp_hdb_ff;
   assign rsp_ch.updated        = rsp_upd_ff;

   `WMMD_ASSERT(a_fill_bound, clock, reset, fill_count_ff <= DEPTH_C)
   `WMMD_ASSERT_IMPL(a_read_in_walk, clock, reset, rd_vld_ff, state_ff == wmmd_pkg::ST_WALK)
   `WMMD_ASSERT_IMPL(a_done_in_wait, clock, reset, div_done, state_ff == wmmd_pkg::ST_DIVW)
   `WMMD_ASSERT_NEXT(a_store_walks, clock, reset, store, state_ff == wmmd_pkg::ST_WALK && iss_ff == '0)

endmodule

[verif/windowed_min_max_mean_deviation_tb.sv]
// ----------------------------------------------------------------------------
// Windowed min / max / mean deviation testbench
// Drives paired temperature and humidity samples through the sample channel
// under random gaps and result stalls, across several store intervals and
// window lengths. A software copy of the window recomputes the held
// deviations for each stored sample; every accepted sample queues a prediction,
// and each result beat is compared field by field with the oldest pending one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
   logic signed [wmmd_pkg::TDEV_W-1:0] t_above;
   logic signed [wmmd_pkg::TDEV_W-1:0] t_below;
   logic signed [wmmd_pkg::HDEV_W-1:0] h_above;
   logic signed [wmmd_pkg::HDEV_W-1:0] h_below;
   logic                               updated;
} dev_beat_type;

class window_deviation_tracker;
   localparam int DEPTH = 64;

   int           temp_win [DEPTH];
   int           hum_win [DEPTH];
   int           wr_idx;
   int           fill;
   int           tick_cnt;
   int           held [4];
   int           tps;
   int           wlen;
   int           errors;
   dev_beat_type pending_devs [$];

   function new();
      tps      = int'(wmmd_pkg::TPS_RESET);
      wlen     = int'(wmmd_pkg::WLEN_RESET);
      wr_idx   = 0;
      fill     = 0;
      tick_cnt = 0;
      errors   = 0;
      foreach (held[i]) held[i] = 0;
      foreach (temp_win[i]) begin
         temp_win[i] = 0;
         hum_win[i]  = 0;
      end
   endfunction

   function void write_reg(logic [wmmd_pkg::CSR_IDX_W-1:0] idx,
                           logic [wmmd_pkg::CSR_DATA_W-1:0] data);
      if (idx == wmmd_pkg::REG_TICKS_PER_STORE) begin
         tps = int'(data);
      end else if (idx == wmmd_pkg::REG_WINDOW_LENGTH) begin
         wlen   = int'(data[wmmd_pkg::WLEN_W-1:0]);
         wr_idx = 0;
         fill   = 0;
      end
   endfunction

   function longint near_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function void take_sample(logic signed [wmmd_pkg::TEMP_W-1:0] t,
                             logic [wmmd_pkg::HUM_W-1:0] h, logic k);
      int           interval;
      int           len;
      int           tmax;
      int           tmin;
      int           hmax;
      int           hmin;
      longint       tsum;
      longint       hsum;
      dev_beat_type beat;
      beat.updated = 1'b0;
      if (k) begin
         interval = (tps == 0) ? 1 : tps;
         if (tick_cnt + 1 >= interval) begin
            len = (wlen == 0) ? 1 : ((wlen > DEPTH) ? DEPTH : wlen);
            tick_cnt = 0;
            if (wr_idx >= len) wr_idx = 0;
            if (fill > len) fill = len;
            temp_win[wr_idx] = int'(t);
            hum_win[wr_idx]  = int'(h);
            wr_idx = (wr_idx + 1 >= len) ? 0 : wr_idx + 1;
            if (fill < len) fill++;
            tmax = temp_win[0];
            tmin = tmax;
            hmax = hum_win[0];
            hmin = hmax;
            tsum = 0;
            hsum = 0;
            for (int i = 0; i < fill; i++) begin
               if (temp_win[i] > tmax) tmax = temp_win[i];
               if (temp_win[i] < tmin) tmin = temp_win[i];
               if (hum_win[i] > hmax) hmax = hum_win[i];
               if (hum_win[i] < hmin) hmin = hum_win[i];
               tsum += longint'(temp_win[i]);
               hsum += longint'(hum_win[i]);
            end
            held[0] = int'(near_div(longint'(tmax) * fill - tsum, longint'(fill)));
            held[1] = int'(near_div(longint'(tmin) * fill - tsum, longint'(fill)));
            held[2] = int'(near_div(longint'(hmax) * fill - hsum, longint'(fill)));
            held[3] = int'(near_div(longint'(hmin) * fill - hsum, longint'(fill)));
            beat.updated = 1'b1;
         end else begin
            tick_cnt = (tick_cnt + 1) & 255;
         end
      end
      beat.t_above = held[0][wmmd_pkg::TDEV_W-1:0];
      beat.t_below = held[1][wmmd_pkg::TDEV_W-1:0];
      beat.h_above = held[2][wmmd_pkg::HDEV_W-1:0];
      beat.h_below = held[3][wmmd_pkg::HDEV_W-1:0];
      pending_devs.push_back(beat);
   endfunction

   function void check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
      end
   endfunction

   function void match_result(dev_beat_type got);
      dev_beat_type want;
      if (pending_devs.size() == 0) begin
         errors++;
         $display("%0t: result beat with no pending sample: expected none, %s %0d %0d %0d %0d %0d",
                  $time, "actual", got.t_above, got.t_below, got.h_above, got.h_below,
                  got.updated);
         return;
      end
      want = pending_devs.pop_front();
      check_field("temp_dev_above", int'(want.t_above), int'(got.t_above));
      check_field("temp_dev_below", int'(want.t_below), int'(got.t_below));
      check_field("hum_dev_above", int'(want.h_above), int'(got.h_above));
      check_field("hum_dev_below", int'(want.h_below), int'(got.h_below));
      check_field("updated", int'(want.updated), int'(got.updated));
   endfunction

   function int waiting();
      return pending_devs.size();
   endfunction
endclass

module windowed_min_max_mean_deviation_tb;

   localparam int IDX_W  = wmmd_pkg::CSR_IDX_W;
   localparam int DATA_W = wmmd_pkg::CSR_DATA_W;
   localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;
   localparam int IDLE_PCT   = 31;
   localparam int HANG_LIMIT = 4000;
   localparam int TAIL       = 400;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [IDX_W-1:0]  csr_index;
   logic [DATA_W-1:0] csr_wdata;
   bit                steady = 1'b0;
   int                idle_cycles = 0;

   window_deviation_tracker tracker = new();

   wmmd_req_if req ();
   wmmd_rsp_if rsp ();

   windowed_min_max_mean_deviation uut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req),
      .rsp_ch   (rsp),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : watch
      dev_beat_type got;
      if (!reset) begin
         if (req.valid && req.ready) begin
            tracker.take_sample(req.temperature, req.humidity, req.tick);
         end
         if (rsp.valid && rsp.ready) begin
            got.t_above = rsp.temp_dev_above;
            got.t_below = rsp.temp_dev_below;
            got.h_above = rsp.hum_dev_above;
            got.h_below = rsp.hum_dev_below;
            got.updated = rsp.updated;
            tracker.match_result(got);
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic offer_sample(int t, int h, bit k);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.temperature <= t[wmmd_pkg::TEMP_W-1:0];
      req.humidity    <= h[wmmd_pkg::HUM_W-1:0];
      req.tick        <= k;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic offer_random();
      int t;
      int h;
      t = $urandom_range(1200) - 400;
      h = $urandom_range(1000);
      if ($urandom_range(9) == 0) t = $urandom_range(1) ? 800 : -400;
      if ($urandom_range(9) == 0) h = $urandom_range(1) ? 1000 : 0;
      offer_sample(t, h, $urandom_range(99) < 80);
   endtask

   task automatic wait_results();
      req.valid <= 1'b0;
      while (tracker.waiting() != 0) @(negedge clock);
   endtask

   task automatic set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(logic [DATA_W-1:0] tps, logic [DATA_W-1:0] wl,
                            int count, int pause_at);
      wait_results();
      set_reg(wmmd_pkg::REG_TICKS_PER_STORE, tps);
      set_reg(wmmd_pkg::REG_WINDOW_LENGTH, wl);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) wait_results();
         offer_random();
      end
   endtask

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = wmmd_pkg::REG_TICKS_PER_STORE;
      csr_wdata       = '0;
      req.valid       = 1'b0;
      req.temperature = '0;
      req.humidity    = '0;
      req.tick        = 1'b0;
      rsp.ready       = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer_sample(0, 0, 1'b0);
      offer_sample(800, 1000, 1'b1);

      wait_results();
      set_reg(wmmd_pkg::REG_TICKS_PER_STORE, 8'd1);
      set_reg(wmmd_pkg::REG_WINDOW_LENGTH, 8'd4);
      offer_sample(800, 1000, 1'b1);
      offer_sample(-400, 0, 1'b1);
      offer_sample(0, 0, 1'b1);
      offer_sample(-400, 1000, 1'b0);
      offer_sample(-400, 1000, 1'b1);
      offer_sample(800, 0, 1'b1);
      offer_sample(-1, 1, 1'b1);
      offer_sample(1, 999, 1'b1);

      wait_results();
      set_reg(wmmd_pkg::REG_TICKS_PER_STORE, 8'd0);
      set_reg(wmmd_pkg::REG_WINDOW_LENGTH, 8'd0);
      offer_sample(5, 5, 1'b1);
      offer_sample(-5, 7, 1'b1);
      offer_sample(0, 0, 1'b0);

      wait_results();
      set_reg(wmmd_pkg::REG_WINDOW_LENGTH, 8'd100);
      set_reg(wmmd_pkg::REG_TICKS_PER_STORE, 8'd200);
      repeat (6) offer_sample($urandom_range(1200) - 400, $urandom_range(1000), 1'b1);
      wait_results();
      set_reg(wmmd_pkg::REG_TICKS_PER_STORE, 8'd3);
      offer_sample(100, 100, 1'b1);
      wait_results();
      set_reg(REG_SPARE_2, 8'hFF);
      set_reg(REG_SPARE_3, 8'h00);
      offer_sample(7, 7, 1'b1);
      offer_sample(8, 8, 1'b1);
      offer_sample(9, 9, 1'b1);

      run_phase(8'd1, 8'd64, 200, 100);
      run_phase(8'd1, 8'd1, 60, -1);
      wait_results();
      steady = 1'b1;
      run_phase(8'd2, 8'd7, 150, -1);
      wait_results();
      steady = 1'b0;
      run_phase(8'd255, 8'd64, 350, -1);
      run_phase(8'd3, 8'd100, 150, -1);
      run_phase(8'd0, 8'd127, 150, -1);
      run_phase(8'd1, 8'hC1, 100, -1);
      run_phase(8'd1, 8'd33, 200, -1);
      run_phase(8'd5, 8'd10, 100, -1);
      repeat (5) begin
         run_phase(DATA_W'($urandom_range(1, 4)), DATA_W'($urandom_range(1, 64)), 100, -1);
      end

      wait_results();
      repeat (TAIL) @(negedge clock);
      if (tracker.errors == 0 && tracker.waiting() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+sv
sv/wmmd_pkg.sv
sv/wmmd_ifs.sv
sv/wmmd_div.sv
sv/windowed_min_max_mean_deviation.sv
verif/windowed_min_max_mean_deviation_tb.sv
